@@ src/dual_axis_kalman_observer_core_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros for the dual-axis Kalman observer
// Concurrent checks on clk_i, disabled while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef DUAL_AXIS_KALMAN_OBSERVER_CORE_MACROS_SVH
`define DUAL_AXIS_KALMAN_OBSERVER_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define DAKO_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DAKO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DAKO_ASSERT(lbl, ante, cons, msg)
`define DAKO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/dako_pkg.sv @@
// -----------------------------------------------------------------------------
// dako_pkg
// Shared types, constants and address helpers of the dual-axis observer.
// -----------------------------------------------------------------------------
package dako_pkg;

  localparam int DATA_W      = 32;
  localparam int ACC_W       = 50;
  localparam int PROD_W      = 64;
  localparam int ADDR_W      = 6;
  localparam int MEM_DEPTH   = 64;
  localparam int OFF_W       = 4;
  localparam int NUM_CFG     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int DEN_W       = 33;
  localparam int CLR_W       = 5;
  localparam int AXIS_ENTRIES = 12;

  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(2 * AXIS_ENTRIES - 1);

  localparam logic signed [DATA_W-1:0] SYS_A22  = 32'sd65536;
  localparam logic signed [DATA_W-1:0] A_ONE    = 32'sd65536;
  localparam logic signed [DATA_W-1:0] COV_ONE  = 32'sh4000_0000;
  localparam logic signed [DATA_W-1:0] Q_NOISE  = 32'sd107374;
  localparam logic signed [DATA_W-1:0] R_NOISE  = 32'sd53687091;
  localparam logic signed [DATA_W-1:0] SAT_MAX  = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN  = 32'sh8000_0000;

  // per-axis block: P at 0..8, state at 9..11
  localparam logic [OFF_W-1:0]  OFF_ST     = 4'd9;
  // scratch, shared by both axes
  localparam logic [ADDR_W-1:0] T_BASE     = 6'd32;
  localparam logic [ADDR_W-1:0] PP_BASE    = 6'd41;
  localparam logic [ADDR_W-1:0] PRED_BASE  = 6'd50;
  localparam logic [ADDR_W-1:0] INNOV_ADDR = 6'd53;

  typedef enum logic [1:0] {
    SH_PASS,
    SH_16,
    SH_30
  } shift_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_PRED,
    ST_TMUL,
    ST_PMUL,
    ST_GRD,
    ST_GCHK,
    ST_GWAIT,
    ST_INNOV,
    ST_SUPD,
    ST_CUPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] meas_x;
    logic signed [DATA_W-1:0] meas_y;
    logic                     clear_filter;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] est_pos_x;
    logic signed [DATA_W-1:0] est_vel_x;
    logic signed [DATA_W-1:0] est_zmp_x;
    logic signed [DATA_W-1:0] est_pos_y;
    logic signed [DATA_W-1:0] est_vel_y;
    logic signed [DATA_W-1:0] est_zmp_y;
  } out_t;

  // one product term issued to the MAC pipe
  typedef struct packed {
    logic                     valid;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] coef;
    shift_e                   shift;
    logic                     sub;
    logic                     first;
    logic                     last;
    logic signed [DATA_W-1:0] bias;
    logic [ADDR_W-1:0]        dest;
  } term_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_t;

  function automatic logic [OFF_W-1:0] idx3(input logic [1:0] r, input logic [1:0] c);
    return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic [ADDR_W-1:0] p_addr(input logic axis,
                                               input logic [OFF_W-1:0] off);
    return {1'b0, axis, off};
  endfunction

  function automatic logic [ADDR_W-1:0] s_addr(input logic [ADDR_W-1:0] base,
                                               input logic [OFF_W-1:0] off);
    return base + {2'b00, off};
  endfunction

  function automatic logic signed [DATA_W-1:0] cfg_reset(input logic [CFG_IDX_W-1:0] idx);
    return (idx == 3'd0 || idx == 3'd4) ? A_ONE : '0;
  endfunction

endpackage

@@ src/dual_axis_kalman_observer_core.sv @@
// Per axis: 9+27+27+1+6+18 MAC issues, one drain of the MAC pipe per phase, and
// three gain divisions on the shared radix-2 divider, or none when the denominator
// is not positive. One word at a time; the next word is taken while the result waits.
// Reset: system matrix to identity; a clear pass writes identity covariance
// and zero state into the state RAM before the first input word is taken.
// -----------------------------------------------------------------------------
// dual_axis_kalman_observer_core
// Two three-state Kalman filters (x, y) over one state RAM and one MAC pipe.
// -----------------------------------------------------------------------------
`include "dual_axis_kalman_observer_core_macros.svh"

module dual_axis_kalman_observer_core import dako_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  // RAM map: x block 0..11, y block 16..27 (P row-major then state),
  // scratch T, PP, pred, innovation from 32 up, reused by each axis.
  logic [DATA_W-1:0]        mem_q [MEM_DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     mw_en;
  logic [ADDR_W-1:0]        mw_addr;
  logic [DATA_W-1:0]        mw_data;

  logic signed [DATA_W-1:0] sys_q [NUM_CFG];

  state_e state_q, state_d;
  in_t    in_q;
  logic   axis_q, pend_q, iss_done_q;
  logic [1:0] i_q, j_q, k_q, gi_q;
  logic [1:0] imax, jmax, kmax;
  logic   phase_act, phase_end, accept;
  logic [CLR_W-1:0] clr_q;
  logic   cl_axis;
  logic [OFF_W-1:0] cl_off;

  logic signed [DEN_W-1:0]  den_q, den_use;
  logic                     den_ok;
  logic signed [DATA_W-1:0] gain_q [3];
  logic signed [DATA_W-1:0] est_q [2][3];
  logic                     out_valid_q;
  out_t                     out_q;

  term_t iss;
  wr_t   eng_wr;
  logic  eng_busy;
  logic  div_start, div_busy, div_done;
  logic signed [DATA_W-1:0] div_quo;
  logic  est_hit;

  function automatic logic signed [DATA_W-1:0] a_coef(input logic [1:0] r,
                                                      input logic [1:0] c);
    logic [OFF_W-1:0] n;
    n = idx3(r, c);
    return (n == 4'd8) ? SYS_A22 : sys_q[n[CFG_IDX_W-1:0]];
  endfunction

  assign accept = in_valid_i && in_ready_o;

  // loop bounds of each MAC phase
  always_comb begin
    imax      = 2'd2;
    jmax      = 2'd0;
    kmax      = 2'd2;
    phase_act = 1'b1;
    unique case (state_q)
      ST_PRED:  ;
      ST_TMUL:  jmax = 2'd2;
      ST_PMUL:  jmax = 2'd2;
      ST_INNOV: begin
        imax = 2'd0;
        kmax = 2'd0;
      end
      ST_SUPD:  kmax = 2'd1;
      ST_CUPD:  begin
        jmax = 2'd2;
        kmax = 2'd1;
      end
      default:  phase_act = 1'b0;
    endcase
  end

  assign phase_end = phase_act && iss_done_q && !eng_busy;

  // gain denominator: P(0,0) + R, taken from the first PP read
  always_comb begin
    den_use = (gi_q == 2'd0) ? (DEN_W'(rdata_q) + DEN_W'(R_NOISE)) : den_q;
    den_ok  = !den_use[DEN_W-1] && (den_use != '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:   if (clr_q == CLR_LAST) state_d = pend_q ? ST_PRED : ST_IDLE;
      ST_IDLE:  if (accept) state_d = in_data_i.clear_filter ? ST_CLR : ST_PRED;
      ST_PRED:  if (phase_end) state_d = ST_TMUL;
      ST_TMUL:  if (phase_end) state_d = ST_PMUL;
      ST_PMUL:  if (phase_end) state_d = ST_GRD;
      ST_GRD:   state_d = ST_GCHK;
      ST_GCHK:  begin
        if (den_ok) begin
          state_d = ST_GWAIT;
        end else begin
          state_d = (gi_q == 2'd2) ? ST_INNOV : ST_GRD;
        end
      end
      ST_GWAIT: if (div_done) state_d = (gi_q == 2'd2) ? ST_INNOV : ST_GRD;
      ST_INNOV: if (phase_end) state_d = ST_SUPD;
      ST_SUPD:  if (phase_end) state_d = ST_CUPD;
      ST_CUPD:  if (phase_end) state_d = axis_q ? ST_DONE : ST_PRED;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs: MAC issue, RAM read address, divider start, clear writes
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    iss        = '0;
    iss.valid  = phase_act && !iss_done_q;
    iss.first  = (k_q == 2'd0);
    iss.last   = (k_q == kmax);
    iss.shift  = SH_16;
    div_start  = 1'b0;
    unique case (state_q)
      ST_PRED: begin
        iss.addr = p_addr(axis_q, OFF_ST + {2'b00, k_q});
        iss.coef = a_coef(i_q, k_q);
        iss.dest = s_addr(PRED_BASE, {2'b00, i_q});
      end
      ST_TMUL: begin
        iss.addr = p_addr(axis_q, idx3(k_q, j_q));
        iss.coef = a_coef(i_q, k_q);
        iss.dest = s_addr(T_BASE, idx3(i_q, j_q));
      end
      ST_PMUL: begin
        // A*P*A^T, process noise on the diagonal
        iss.addr = s_addr(T_BASE, idx3(i_q, k_q));
        iss.coef = a_coef(j_q, k_q);
        iss.bias = (i_q == j_q) ? Q_NOISE : '0;
        iss.dest = s_addr(PP_BASE, idx3(i_q, j_q));
      end
      ST_INNOV: begin
        iss.addr  = PRED_BASE;
        iss.shift = SH_PASS;
        iss.sub   = 1'b1;
        iss.bias  = axis_q ? in_q.meas_y : in_q.meas_x;
        iss.dest  = INNOV_ADDR;
      end
      ST_SUPD: begin
        // pred + K*innov
        if (k_q == 2'd0) begin
          iss.addr  = s_addr(PRED_BASE, {2'b00, i_q});
          iss.shift = SH_PASS;
        end else begin
          iss.addr  = INNOV_ADDR;
          iss.coef  = gain_q[i_q];
          iss.shift = SH_30;
        end
        iss.dest = p_addr(axis_q, OFF_ST + {2'b00, i_q});
      end
      ST_CUPD: begin
        // PP(i,j) - K(i)*PP(0,j)
        if (k_q == 2'd0) begin
          iss.addr  = s_addr(PP_BASE, idx3(i_q, j_q));
          iss.shift = SH_PASS;
        end else begin
          iss.addr  = s_addr(PP_BASE, {2'b00, j_q});
          iss.coef  = gain_q[i_q];
          iss.shift = SH_30;
          iss.sub   = 1'b1;
        end
        iss.dest = p_addr(axis_q, idx3(i_q, j_q));
      end
      ST_GCHK: div_start = den_ok;
      default: ;
    endcase

    rd_addr = (state_q == ST_GRD) ? s_addr(PP_BASE, idx3(gi_q, 2'd0)) : iss.addr;

    cl_axis = (clr_q >= CLR_W'(AXIS_ENTRIES));
    cl_off  = cl_axis ? OFF_W'(clr_q - CLR_W'(AXIS_ENTRIES)) : clr_q[OFF_W-1:0];
    if (state_q == ST_CLR) begin
      mw_en   = 1'b1;
      mw_addr = p_addr(cl_axis, cl_off);
      mw_data = (cl_off == 4'd0 || cl_off == 4'd4 || cl_off == 4'd8) ? COV_ONE : '0;
    end else begin
      mw_en   = eng_wr.en;
      mw_addr = eng_wr.addr;
      mw_data = eng_wr.data;
    end

    est_hit = eng_wr.en && !eng_wr.addr[ADDR_W-1] && (eng_wr.addr[OFF_W-1:0] >= OFF_ST);
  end

  // state RAM, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mw_en) begin
      mem_q[mw_addr] <= mw_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  dako_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .iss_i   (iss),
    .rdata_i (rdata_q),
    .wr_o    (eng_wr),
    .busy_o  (eng_busy)
  );

  dako_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rdata_q),
    .den_i   (den_use),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      axis_q      <= 1'b0;
      pend_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      iss_done_q  <= 1'b0;
      gi_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int n = 0; n < NUM_CFG; n++) begin
        sys_q[n] <= cfg_reset(CFG_IDX_W'(n));
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        sys_q[cfg_idx_i] <= cfg_data_i;
      end

      if (accept) begin
        axis_q <= 1'b0;
        pend_q <= 1'b1;
      end else if (state_q == ST_CUPD && phase_end) begin
        axis_q <= 1'b1;
      end else if (state_q == ST_DONE && state_d == ST_IDLE) begin
        pend_q <= 1'b0;
      end

      // i/j/k walk over the elements and terms of the current phase
      if (state_q != state_d) begin
        i_q        <= '0;
        j_q        <= '0;
        k_q        <= '0;
        iss_done_q <= 1'b0;
      end else if (iss.valid) begin
        if (k_q != kmax) begin
          k_q <= k_q + 2'd1;
        end else begin
          k_q <= '0;
          if (j_q != jmax) begin
            j_q <= j_q + 2'd1;
          end else begin
            j_q <= '0;
            if (i_q != imax) begin
              i_q <= i_q + 2'd1;
            end else begin
              iss_done_q <= 1'b1;
            end
          end
        end
      end

      if (state_q == ST_PMUL) begin
        gi_q <= '0;
      end else if ((state_q == ST_GCHK && !den_ok) || (state_q == ST_GWAIT && div_done)) begin
        gi_q <= gi_q + 2'd1;
      end

      if (state_q == ST_CLR) begin
        clr_q <= (clr_q == CLR_LAST) ? '0 : clr_q + 5'd1;
      end

      if (state_q == ST_DONE && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (state_q == ST_GCHK && gi_q == 2'd0) begin
      den_q <= den_use;
    end
    if (state_q == ST_GCHK && !den_ok) begin
      gain_q[gi_q] <= '0;
    end else if (state_q == ST_GWAIT && div_done) begin
      gain_q[gi_q] <= div_quo;
    end
    // shadow of the updated states, copied out at the end
    if (est_hit) begin
      est_q[eng_wr.addr[OFF_W]][2'(eng_wr.addr[OFF_W-1:0] - OFF_ST)] <= eng_wr.data;
    end
    if (state_q == ST_DONE && state_d == ST_IDLE) begin
      out_q.est_pos_x <= est_q[0][0];
      out_q.est_vel_x <= est_q[0][1];
      out_q.est_zmp_x <= est_q[0][2];
      out_q.est_pos_y <= est_q[1][0];
      out_q.est_vel_y <= est_q[1][1];
      out_q.est_zmp_y <= est_q[1][2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DAKO_ASSERT(a_clr_quiet, state_q == ST_CLR, !eng_busy, "MAC pipe active during clear pass")
  `DAKO_ASSERT(a_div_start, div_start, den_ok && !div_busy, "divider started badly")
  `DAKO_ASSERT(a_phase_issue, iss.valid, !div_busy, "MAC issue while divider runs")
  `DAKO_ASSERT_NEXT(a_out_load, state_q == ST_DONE && state_d == ST_IDLE, out_valid_o,
                    "result not presented")
  `DAKO_ASSERT_NEXT(a_one_word, accept, !in_ready_o, "second word taken while busy")

endmodule

@@ src/dako_mac.sv @@
// -----------------------------------------------------------------------------
// dako_mac
// Multiply, round and accumulate pipe with saturating write-back.
// -----------------------------------------------------------------------------
module dako_mac import dako_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  term_t                    iss_i,
  input  logic signed [DATA_W-1:0] rdata_i,
  output wr_t                      wr_o,
  output logic                     busy_o
);

  localparam logic signed [PROD_W-1:0] RND16 = 64'sd32768;
  localparam logic signed [PROD_W-1:0] RND30 = 64'sd536870912;

  term_t s1_q, s2_q, s3_q;
  wr_t   wr_q;

  logic signed [PROD_W-1:0] prod_d, prod_q, rnd;
  logic signed [ACC_W-1:0]  term_q, acc_q, base, acc_n;
  logic signed [DATA_W-1:0] sat_v;

  // stage 1: product
  always_comb begin
    if (s1_q.shift == SH_PASS) begin
      prod_d = PROD_W'(rdata_i);
    end else begin
      prod_d = s1_q.coef * rdata_i;
    end
  end

  // stage 2: round to nearest, ties up
  always_comb begin
    unique case (s2_q.shift)
      SH_PASS: rnd = prod_q;
      SH_16:   rnd = (prod_q + RND16) >>> 16;
      SH_30:   rnd = (prod_q + RND30) >>> 30;
      default: rnd = prod_q;
    endcase
  end

  // stage 3: accumulate and clamp
  always_comb begin
    base  = s3_q.first ? ACC_W'(s3_q.bias) : acc_q;
    acc_n = s3_q.sub ? base - term_q : base + term_q;
    if (acc_n > ACC_W'(SAT_MAX)) begin
      sat_v = SAT_MAX;
    end else if (acc_n < ACC_W'(SAT_MIN)) begin
      sat_v = SAT_MIN;
    end else begin
      sat_v = acc_n[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      wr_q <= '0;
    end else begin
      s1_q    <= iss_i;
      s2_q    <= s1_q;
      s3_q    <= s2_q;
      wr_q.en <= s3_q.valid && s3_q.last;
      wr_q.addr <= s3_q.dest;
      wr_q.data <= sat_v;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    term_q <= rnd[ACC_W-1:0];
    if (s3_q.valid) begin
      acc_q <= acc_n;
    end
  end

  assign wr_o   = wr_q;
  assign busy_o = s1_q.valid | s2_q.valid | s3_q.valid | wr_q.en;

endmodule

@@ src/dako_div.sv @@
// -----------------------------------------------------------------------------
// dako_div
// Radix-2 restoring divider for the Kalman gain, Q2.30 result, saturating.
// -----------------------------------------------------------------------------
module dako_div import dako_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] num_i,
  input  logic signed [DEN_W-1:0]  den_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] quo_o
);

  logic              busy_q, done_q, neg_q;
  logic [4:0]        cnt_q;
  logic [DATA_W-1:0] den_q, rem_q, shf_q, qb_q;
  logic [DATA_W-1:0] mag, den_u, rem_n, qb_n;
  logic [DATA_W:0]   rem2;
  logic              ovf, ge, last;
  logic signed [DATA_W-1:0] quo_q;

  function automatic logic signed [DATA_W-1:0] fin(input logic [DATA_W-1:0] q,
                                                   input logic neg);
    if (!neg) begin
      return q[DATA_W-1] ? SAT_MAX : q;
    end
    return (q[DATA_W-1] && (|q[DATA_W-2:0])) ? SAT_MIN : (~q + 1'b1);
  endfunction

  always_comb begin
    mag   = num_i[DATA_W-1] ? (~num_i + 1'b1) : num_i;
    den_u = den_i[DATA_W-1:0];
    ovf   = {2'b00, mag} >= {den_u, 2'b00};
    rem2  = {rem_q, shf_q[DATA_W-1]};
    ge    = rem2 >= {1'b0, den_q};
    rem_n = ge ? 32'(rem2 - {1'b0, den_q}) : rem2[DATA_W-1:0];
    qb_n  = {qb_q[DATA_W-2:0], ge};
    last  = (cnt_q == 5'd31);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !ovf;
        done_q <= ovf;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DATA_W-1];
      den_q <= den_u;
      rem_q <= {2'b00, mag[DATA_W-1:2]};
      shf_q <= {mag[1:0], 30'b0};
      qb_q  <= '0;
      if (ovf) begin
        quo_q <= num_i[DATA_W-1] ? SAT_MIN : SAT_MAX;
      end
    end else if (busy_q) begin
      rem_q <= rem_n;
      shf_q <= {shf_q[DATA_W-2:0], 1'b0};
      qb_q  <= qb_n;
      if (last) begin
        quo_q <= fin(qb_n, neg_q);
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ bench/dako_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dako_checker
// Watches the input, output and register ports of the dual-axis observer,
// predicts each output word in fixed point and compares it field by field.
// -----------------------------------------------------------------------------
module dako_checker import dako_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_t                 out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef logic signed [DATA_W-1:0] word_t;

  word_t sys_m [3][3];
  word_t cov_m [2][9];
  word_t est_m [2][3];
  out_t  est_fifo [$];
  int    fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = est_fifo.size();

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic word_t sat(longint v);
    if (v > longint'(SAT_MAX)) return SAT_MAX;
    if (v < longint'(SAT_MIN)) return SAT_MIN;
    return word_t'(v);
  endfunction

  function automatic void clear_axes();
    for (int ax = 0; ax < 2; ax++) begin
      for (int i = 0; i < 9; i++) cov_m[ax][i] = (i % 4 == 0) ? COV_ONE : '0;
      for (int i = 0; i < 3; i++) est_m[ax][i] = '0;
    end
  endfunction

  function automatic void set_reg(int idx, word_t v);
    sys_m[idx / 3][idx % 3] = v;
  endfunction

  // predict, then scalar correction on state 0
  function automatic void update_axis(int ax, longint meas);
    word_t  t [9];
    word_t  pp [9];
    word_t  pred [3];
    word_t  gain [3];
    longint acc;
    longint denom;
    longint innov;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++)
        acc += rnd_shift(longint'(sys_m[i][k]) * longint'(est_m[ax][k]), 16);
      pred[i] = sat(acc);
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += rnd_shift(longint'(sys_m[i][k]) * longint'(cov_m[ax][k*3+j]), 16);
        t[i*3+j] = sat(acc);
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += rnd_shift(longint'(t[i*3+k]) * longint'(sys_m[j][k]), 16);
        if (i == j) acc += longint'(Q_NOISE);
        pp[i*3+j] = sat(acc);
      end
    denom = longint'(pp[0]) + longint'(R_NOISE);
    for (int i = 0; i < 3; i++)
      gain[i] = (denom <= 0) ? '0 : sat((longint'(pp[i*3]) <<< 30) / denom);
    innov = longint'(sat(meas - longint'(pred[0])));
    for (int i = 0; i < 3; i++)
      est_m[ax][i] = sat(longint'(pred[i]) + rnd_shift(longint'(gain[i]) * innov, 30));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cov_m[ax][i*3+j] = sat(longint'(pp[i*3+j]) -
                               rnd_shift(longint'(gain[i]) * longint'(pp[j]), 30));
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(string what, word_t got, word_t want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d want %0d", what, got, want));
  endtask

  initial begin
    for (int i = 0; i < 9; i++) set_reg(i, (i == 0 || i == 4) ? A_ONE : '0);
    sys_m[2][2] = SYS_A22;
    clear_axes();
  end

  always @(posedge clk_i) begin
    out_t nxt;
    out_t want;
    if (rst_ni) begin
      if (cfg_we_i && cfg_idx_i < NUM_CFG) set_reg(int'(cfg_idx_i), word_t'(cfg_data_i));
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.clear_filter) clear_axes();
        update_axis(0, longint'(in_data_i.meas_x));
        update_axis(1, longint'(in_data_i.meas_y));
        nxt.est_pos_x = est_m[0][0];
        nxt.est_vel_x = est_m[0][1];
        nxt.est_zmp_x = est_m[0][2];
        nxt.est_pos_y = est_m[1][0];
        nxt.est_vel_y = est_m[1][1];
        nxt.est_zmp_y = est_m[1][2];
        est_fifo.insert(est_fifo.size(), nxt);
      end
      if (out_valid_i && out_ready_i) begin
        if (est_fifo.size() == 0) begin
          report_mismatch("output word with nothing expected");
        end else begin
          want = est_fifo.pop_front();
          check_field("est_pos_x", out_data_i.est_pos_x, want.est_pos_x);
          check_field("est_vel_x", out_data_i.est_vel_x, want.est_vel_x);
          check_field("est_zmp_x", out_data_i.est_zmp_x, want.est_zmp_x);
          check_field("est_pos_y", out_data_i.est_pos_y, want.est_pos_y);
          check_field("est_vel_y", out_data_i.est_vel_y, want.est_vel_y);
          check_field("est_zmp_y", out_data_i.est_zmp_y, want.est_zmp_y);
        end
      end
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Drives the dual-axis observer with directed and random measurement words
// over several system matrices; a checker beside the core scores the outputs.
// -----------------------------------------------------------------------------
module testbench import dako_pkg::*; ();

  // worst case per word over all words, plus receiver stalls: far above need
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int     DRAIN_WAIT  = 600;   // beyond one word of core latency
  localparam int     PHASE_WORDS = 250;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_t                  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  int     fail_count;
  int     pending;
  int     tx_idle_pct;
  int     rx_idle_pct;
  int     words_sent;
  int     cfg_sets;
  longint cycles = 0;
  logic signed [DATA_W-1:0] walk_x;
  logic signed [DATA_W-1:0] walk_y;

  always #6 clk_i = ~clk_i;

  dual_axis_kalman_observer_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  dako_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver backpressure, rerolled every cycle
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= rx_idle_pct);

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dual_axis_kalman_observer_core verification failed");
      $finish;
    end
  end

  // register write; entered and left at a falling edge
  task automatic cfg_write(int idx, logic [DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDX_W'(idx);
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic cfg_all(logic [DATA_W-1:0] a00, logic [DATA_W-1:0] a01,
                         logic [DATA_W-1:0] a02, logic [DATA_W-1:0] a10,
                         logic [DATA_W-1:0] a11, logic [DATA_W-1:0] a12,
                         logic [DATA_W-1:0] a20, logic [DATA_W-1:0] a21);
    cfg_write(0, a00); cfg_write(1, a01); cfg_write(2, a02); cfg_write(3, a10);
    cfg_write(4, a11); cfg_write(5, a12); cfg_write(6, a20); cfg_write(7, a21);
    cfg_sets++;
  endtask

  // one measurement word; valid holds until accepted
  task automatic send(logic [DATA_W-1:0] mx, logic [DATA_W-1:0] my, logic clr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{meas_x: mx, meas_y: my, clear_filter: clr};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  // pause the sender until every output word is back, then let the core settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] rand_coef();
    case ($urandom_range(5))
      0:       return $urandom;                        // anything at all
      1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return DATA_W'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // mostly a noisy trajectory, sometimes full-range junk
  task automatic random_phase(int n);
    logic [DATA_W-1:0] mx;
    logic [DATA_W-1:0] my;
    for (int i = 0; i < n; i++) begin
      walk_x += DATA_W'($signed($urandom_range(8192)) - 4096);
      walk_y += DATA_W'($signed($urandom_range(8192)) - 4096);
      mx = walk_x;
      my = walk_y;
      if ($urandom_range(15) == 0) mx = $urandom;
      if ($urandom_range(15) == 0) my = $urandom;
      send(mx, my, ($urandom_range(29) == 0));
    end
  endtask

  initial begin
    words_sent = 0; cfg_sets = 0;
    tx_idle_pct = 21; rx_idle_pct = 73;
    walk_x = '0; walk_y = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed: reset matrix, field extremes, clear on and off
    send(32'h0001_0000, 32'hffff_0000, 1'b0);
    send(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send(32'h0000_0000, 32'h0000_0000, 1'b1);
    send(32'hffff_ffff, 32'h0000_0001, 1'b0);
    send(32'h5555_5555, 32'haaaa_aaaa, 1'b1);
    send(32'haaaa_aaaa, 32'h5555_5555, 1'b0);
    drain();

    // constant-velocity style model, dt ~ 1/64
    cfg_all(32'h0001_0000, 32'h0000_0400, 32'h0000_0100, 32'h0000_0000,
            32'h0001_0000, 32'h0000_0400, 32'h0000_0000, 32'h0000_0000);
    for (int i = 0; i < 6; i++) send(DATA_W'(i * 32'h0000_4000), DATA_W'(-i * 1000), i == 0);
    drain();

    // all max: saturates covariance and state hard
    cfg_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send(32'h7fff_ffff, 32'h8000_0000, 1'b1);
    send(32'h0001_0000, 32'h0001_0000, 1'b0);
    send(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    drain();

    // all min: most negative coefficients; the gain is zero wherever PP(0,0) + R is not positive
    cfg_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(32'h0100_0000, 32'hff00_0000, 1'b1);
    send(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send(32'h0000_0000, 32'h0000_0000, 1'b0);
    drain();

    // zero matrix but the fixed A22: predicted covariance collapses to Q outside (2,2)
    cfg_all('0, '0, '0, '0, '0, '0, '0, '0);
    send(32'h0003_0000, 32'hfffd_0000, 1'b1);
    send(32'h0003_0000, 32'hfffd_0000, 1'b0);
    drain();

    // --- random phases over fresh matrices, idle pattern changing
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin tx_idle_pct = 73; rx_idle_pct = 21; end
      if (ph == 4) begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      if (ph == 0)
        cfg_all(32'h0001_0000, 32'h0000_0041, 32'h0000_0000, 32'h0000_0000,
                32'h0001_0000, 32'h0000_0041, 32'h0000_0000, 32'h0000_0000);
      else
        cfg_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                rand_coef(), rand_coef(), rand_coef(), rand_coef());
      send(walk_x, walk_y, 1'b1);
      random_phase(PHASE_WORDS);
      drain();
    end

    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("Run covered %0d measurement words over %0d system matrices,", words_sent,
             cfg_sets + 1);
    $display("including saturating and zero-gain matrices and filter clears.");
    if (fail_count == 0 && pending == 0) begin
      $display("dual_axis_kalman_observer_core verification clean");
    end else begin
      if (pending != 0) $display("%0d output words never arrived", pending);
      $display("dual_axis_kalman_observer_core verification failed");
    end
    $finish;
  end

endmodule
